[sv/avsd_pkg.sv]
`default_nettype none

package avsd_pkg;

    localparam int FS_BITS = 14;
    localparam logic [FS_BITS-1:0] FS_RESET = 14'd5000;
    localparam logic [9:0] HUND_MAX = 10'd999;
    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] POINT_MASK = 8'h7F;
    localparam logic [1:0] LAST_DIGIT = 2'd3;
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int DIV10_SHIFT = 19;

    typedef struct packed {
        logic [3:0] raw_thou;
        logic [3:0] raw_hund;
        logic [3:0] raw_tens;
        logic [3:0] raw_ones;
        logic [3:0] volt_int;
        logic [3:0] volt_tenth;
        logic [3:0] volt_hundth;
    } digits_t;

    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(DIV10_RECIP);
        return 16'(p[31:DIV10_SHIFT]);
    endfunction

    function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
        logic [15:0] r;
        r = x - ((q << 3) + (q << 1));
        return r[3:0];
    endfunction

    // codes above nine wrap as the decimal digit modulo ten
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0, 4'd10: s = 8'hC0;
            4'd1, 4'd11: s = 8'hF9;
            4'd2, 4'd12: s = 8'hA4;
            4'd3, 4'd13: s = 8'hB0;
            4'd4, 4'd14: s = 8'h99;
            4'd5, 4'd15: s = 8'h92;
            4'd6: s = 8'h82;
            4'd7: s = 8'hF8;
            4'd8: s = 8'h80;
            4'd9: s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[sv/avsd_front.sv]
`default_nettype none

module avsd_front #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [avsd_pkg::FS_BITS-1:0] cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ADC_BITS-1:0]          adc_sample,
    output logic                              push,
    input  wire logic                         push_ready,
    output avsd_pkg::digits_t                 push_data
);

    localparam int FSB = avsd_pkg::FS_BITS;
    localparam int PW = ADC_BITS + FSB;
    localparam int RW = PW - ADC_BITS + 1;
    localparam int MW = PW + RW;
    localparam int STAGES = 7;
    localparam logic [PW-1:0] CONV_MAX = PW'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << PW) / ((64'd1 << ADC_BITS) - 64'd1));

    logic [FSB-1:0] fs_reg;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic adv;

    logic [ADC_BITS-1:0] samp1_reg, samp2_reg, samp3_reg, samp4_reg;
    logic [PW-1:0] prod1_reg, prod2_reg;
    logic [MW-1:0] mul2_reg;
    logic [FSB-1:0] mv3_reg;
    logic [9:0] hund4_reg;
    logic [ADC_BITS-1:0] sq5_reg, sq6_reg;
    logic [6:0] hq5_reg;
    logic [3:0] hq6_reg;
    avsd_pkg::digits_t dig5_reg, dig6_reg, dig7_reg;

    logic [PW-1:0] prod1_next;
    logic [MW-1:0] mul2_next;
    logic [FSB-1:0] qe;
    logic [PW-1:0] qm;
    logic [PW-1:0] rem;
    logic [FSB-1:0] mv3_next;
    logic [29:0] hp;
    logic [10:0] hfull;
    logic [9:0] hund4_next;
    logic [15:0] sq5w, hq5w, sq6w, hq6w, sq7w;
    avsd_pkg::digits_t dig5_next, dig6_next, dig7_next;

    assign adv = !valid_reg[STAGES-1] || push_ready;
    assign in_ready = adv;
    assign push = valid_reg[STAGES-1] && push_ready;
    assign push_data = dig7_reg;
    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        prod1_next = PW'(adc_sample) * PW'(fs_reg);
        mul2_next = MW'(prod1_reg) * MW'(RECIP);

        // reciprocal estimate is exact or one low
        qe = mul2_reg[PW +: FSB];
        qm = (PW'(qe) << ADC_BITS) - PW'(qe);
        rem = prod2_reg - qm;
        mv3_next = qe + FSB'(rem >= CONV_MAX);

        hp = 30'(mv3_reg) * 30'(avsd_pkg::DIV10_RECIP);
        hfull = hp[29:avsd_pkg::DIV10_SHIFT];
        hund4_next = (hfull > 11'(avsd_pkg::HUND_MAX)) ? avsd_pkg::HUND_MAX : hfull[9:0];

        sq5w = avsd_pkg::div10(16'(samp4_reg));
        hq5w = avsd_pkg::div10(16'(hund4_reg));
        dig5_next = '0;
        dig5_next.raw_ones = avsd_pkg::rem10(16'(samp4_reg), sq5w);
        dig5_next.volt_hundth = avsd_pkg::rem10(16'(hund4_reg), hq5w);

        sq6w = avsd_pkg::div10(16'(sq5_reg));
        hq6w = avsd_pkg::div10(16'(hq5_reg));
        dig6_next = dig5_reg;
        dig6_next.raw_tens = avsd_pkg::rem10(16'(sq5_reg), sq6w);
        dig6_next.volt_tenth = avsd_pkg::rem10(16'(hq5_reg), hq6w);

        sq7w = avsd_pkg::div10(16'(sq6_reg));
        dig7_next = dig6_reg;
        dig7_next.raw_hund = avsd_pkg::rem10(16'(sq6_reg), sq7w);
        dig7_next.raw_thou = sq7w[3:0];
        dig7_next.volt_int = hq6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= avsd_pkg::FS_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fs_reg <= cfg_data;
            end
            if (adv)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            samp1_reg <= adc_sample;
            prod1_reg <= prod1_next;
            samp2_reg <= samp1_reg;
            prod2_reg <= prod1_reg;
            mul2_reg <= mul2_next;
            samp3_reg <= samp2_reg;
            mv3_reg <= mv3_next;
            samp4_reg <= samp3_reg;
            hund4_reg <= hund4_next;
            sq5_reg <= sq5w[ADC_BITS-1:0];
            hq5_reg <= hq5w[6:0];
            dig5_reg <= dig5_next;
            sq6_reg <= sq6w[ADC_BITS-1:0];
            hq6_reg <= hq6w[3:0];
            dig6_reg <= dig6_next;
            dig7_reg <= dig7_next;
        end
    end

endmodule

`default_nettype wire

[sv/avsd_queue.sv]
`default_nettype none

module avsd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   push_ready,
    input  wire avsd_pkg::digits_t push_data,
    output logic                   head_valid,
    input  wire logic              pop,
    output avsd_pkg::digits_t      head_data
);

    avsd_pkg::digits_t mem_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/avsd_back.sv]
`default_nettype none

module avsd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire avsd_pkg::digits_t head_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             raw_segments,
    output logic [7:0]             volt_segments,
    output logic [7:0]             digit_enable,
    output logic                   last_digit
);

    logic [1:0] idx_reg;
    logic out_valid_reg;
    logic [7:0] raw_reg, volt_reg, enable_reg;
    logic last_reg;
    logic load;
    logic [3:0] raw_d;
    logic [7:0] raw_next, volt_next, enable_next;
    logic [3:0] onehot;

    assign load = !out_valid_reg || out_ready;
    assign pop = load && head_valid && (idx_reg == avsd_pkg::LAST_DIGIT);

    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                raw_d = head_data.raw_thou;
                volt_next = avsd_pkg::seg_of(head_data.volt_int) & avsd_pkg::POINT_MASK;
            end
            2'd1:
            begin
                raw_d = head_data.raw_hund;
                volt_next = avsd_pkg::seg_of(head_data.volt_tenth);
            end
            2'd2:
            begin
                raw_d = head_data.raw_tens;
                volt_next = avsd_pkg::seg_of(head_data.volt_hundth);
            end
            default:
            begin
                raw_d = head_data.raw_ones;
                volt_next = avsd_pkg::SEG_BLANK;
            end
        endcase
        raw_next = avsd_pkg::seg_of(raw_d);
        onehot = 4'b0001 << idx_reg;
        enable_next = {onehot, onehot};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            raw_reg <= raw_next;
            volt_reg <= volt_next;
            enable_reg <= enable_next;
            last_reg <= (idx_reg == avsd_pkg::LAST_DIGIT);
        end
    end

    assign out_valid = out_valid_reg;
    assign raw_segments = raw_reg;
    assign volt_segments = volt_reg;
    assign digit_enable = enable_reg;
    assign last_digit = last_reg;

endmodule

`default_nettype wire

[sv/adc_voltmeter_seven_segment_unit.sv]
// Scan generator for two 4-digit seven-segment displays: each converter sample becomes four
// results, digit one to four, with the raw code on the first display and the voltage as D.DD
// plus a blank digit on the second (active-low segments, bit 7 the point). A seven-stage front
// pipeline scales the sample by full_scale_mv, divides by the converter maximum and splits both
// values into decimal digits; a two-entry queue feeds the scan stage, which sends one result
// per cycle from its output register while out_ready is high, so the scan stage sets the
// sustained sample rate. With the queue and scan stage idle, a sample passes the seven front
// stages and is written into the queue before its first result is registered in the scan
// output register. full_scale_mv is written on the cfg channel, always ready.
`default_nettype none

module adc_voltmeter_seven_segment_unit #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [avsd_pkg::FS_BITS-1:0] cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ADC_BITS-1:0]          adc_sample,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        raw_segments,
    output logic [7:0]                        volt_segments,
    output logic [7:0]                        digit_enable,
    output logic                              last_digit
);

    logic push;
    logic push_ready;
    avsd_pkg::digits_t push_data;
    logic head_valid;
    logic pop;
    avsd_pkg::digits_t head_data;

    assign cfg_ready = 1'b1;

    avsd_front #(
        .ADC_BITS(ADC_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .adc_sample(adc_sample),
        .push(push),
        .push_ready(push_ready),
        .push_data(push_data)
    );

    avsd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_ready(push_ready),
        .push_data(push_data),
        .head_valid(head_valid),
        .pop(pop),
        .head_data(head_data)
    );

    avsd_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(head_valid),
        .head_data(head_data),
        .pop(pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .raw_segments(raw_segments),
        .volt_segments(volt_segments),
        .digit_enable(digit_enable),
        .last_digit(last_digit)
    );

endmodule

`default_nettype wire
